/* rtl/core/rsa_modexp_pkg.sv */
// shared types and constants of the modular exponentiation block
// no dependencies; compiled first

package rsa_modexp_pkg;

   // default modulus width and fixed payload widths
   localparam int MOD_BITS_DEF = 16;
   localparam int MSG_BITS     = 16;
   localparam int RES_BITS     = 16;

   // configuration register indexes
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MODULUS  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PUB_EXP  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PRIV_EXP = 2'd2;

   // register reset values
   localparam int MODULUS_RST  = 143;
   localparam int PUB_EXP_RST  = 7;
   localparam int PRIV_EXP_RST = 103;

   // request kinds
   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   // status of a multi-cycle unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

/* rtl/core/rsa_modexp_if.sv */
// request and response channel interfaces of the modular exponentiation block
// depends on rsa_modexp_pkg

interface rsa_modexp_req_if import rsa_modexp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [MSG_BITS-1:0] message;

   modport source (output valid, output kind, output message, input ready);
   modport sink   (input valid, input kind, input message, output ready);
endinterface

interface rsa_modexp_rsp_if import rsa_modexp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RES_BITS-1:0] result;
   logic                error;

   modport source (output valid, output result, output error, input ready);
   modport sink   (input valid, input result, input error, output ready);
endinterface

/* rtl/core/rsa_modexp_mulmod.sv */
// shared modular multiplier: one registered multiply, then a bit-serial
// restoring reduction of the double-width product; depends on rsa_modexp_pkg

module rsa_modexp_mulmod
   import rsa_modexp_pkg::*;
#(
   parameter int MOD_BITS = MOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MOD_BITS-1:0] op_a,
   input  logic [MOD_BITS-1:0] op_b,
   input  logic [MOD_BITS-1:0] modulus,
   output logic [MOD_BITS-1:0] remainder,
   output unit_stat_type       stat
);

   localparam int PROD_BITS = 2 * MOD_BITS;
   localparam int CNT_BITS  = $clog2(PROD_BITS + 1);

   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [MOD_BITS-1:0]  rem_ff, rem_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   logic [MOD_BITS:0]    rem_sh;
   logic [MOD_BITS:0]    rem_diff;

   // shift in the next product bit and subtract the modulus once if it fits
   assign rem_sh   = {rem_ff, prod_ff[PROD_BITS-1]};
   assign rem_diff = rem_sh - {1'b0, modulus};

   always_comb begin
      prod_in = prod_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = PROD_BITS'(op_a) * PROD_BITS'(op_b);
         rem_in  = '0;
         cnt_in  = CNT_BITS'(PROD_BITS);
         run_in  = 1'b1;
      end else if (run_ff) begin
         prod_in = prod_ff << 1;
         if (rem_sh >= {1'b0, modulus}) begin
            rem_in = rem_diff[MOD_BITS-1:0];
         end else begin
            rem_in = rem_sh[MOD_BITS-1:0];
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign remainder = rem_ff;
   assign stat.busy = run_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/core/rsa_modexp_engine.sv */
// square-and-multiply sequencer driving the shared modular multiplier
// depends on rsa_modexp_pkg and rsa_modexp_mulmod

module rsa_modexp_engine
   import rsa_modexp_pkg::*;
#(
   parameter int MOD_BITS = MOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                kind,
   input  logic [MOD_BITS-1:0] message,
   input  logic [MOD_BITS-1:0] exponent,
   input  logic [MOD_BITS-1:0] modulus,
   input  logic                ack,
   output logic [MOD_BITS-1:0] result,
   output logic                error,
   output unit_stat_type       stat
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_STEP = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SQR  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] base_ff, base_in;
   logic [MOD_BITS-1:0] exp_ff, exp_in;
   logic                err_ff, err_in;

   logic [MOD_BITS-1:0] exp_sh;
   logic                mm_start;
   logic                mm_square;
   logic [MOD_BITS-1:0] mm_a;
   logic [MOD_BITS-1:0] mm_rem;
   unit_stat_type       mm_stat;

   assign exp_sh = exp_ff >> 1;
   assign mm_a   = mm_square ? base_ff : acc_ff;

   rsa_modexp_mulmod #(
      .MOD_BITS (MOD_BITS)
   ) u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .start     (mm_start),
      .op_a      (mm_a),
      .op_b      (base_ff),
      .modulus   (modulus),
      .remainder (mm_rem),
      .stat      (mm_stat)
   );

   // exponent bits scanned from the bottom: multiply on a one, square between bits
   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      err_in    = err_ff;
      mm_start  = 1'b0;
      mm_square = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               exp_in  = exponent;
               base_in = message;
               err_in  = 1'b0;
               acc_in  = MOD_BITS'(1);
               if (kind == KIND_ENCRYPT && message >= modulus) begin
                  // encrypt of a message not below the modulus
                  err_in   = 1'b1;
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else if (modulus == '0) begin
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (exp_ff == '0) begin
               // exponent zero leaves the unreduced one
               state_in = ST_DONE;
            end else if (!mm_stat.busy) begin
               if (exp_ff[0]) begin
                  mm_start = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  exp_in = exp_sh;
                  if (exp_sh != '0) begin
                     mm_start  = 1'b1;
                     mm_square = 1'b1;
                     state_in  = ST_SQR;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_MUL: begin
            if (mm_stat.done) begin
               acc_in = mm_rem;
               exp_in = exp_sh;
               if (exp_sh != '0) begin
                  mm_start  = 1'b1;
                  mm_square = 1'b1;
                  state_in  = ST_SQR;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SQR: begin
            if (mm_stat.done) begin
               base_in  = mm_rem;
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      base_ff <= base_in;
      exp_ff  <= exp_in;
      err_ff  <= err_in;
   end

   assign result    = acc_ff;
   assign error     = err_ff;
   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.done = (state_ff == ST_DONE);

endmodule

/* rtl/core/rsa_modular_exponentiation.sv */
// modular exponentiation top level: configuration registers, request intake,
// response register; depends on rsa_modexp_pkg, rsa_modexp_if, rsa_modexp_engine
//
// Usage:
//  - csr_we/csr_addr/csr_wdata write the modulus (0), public exponent (1) and
//    private exponent (2); write them only while no request is in flight
//  - req_bus carries kind (0 encrypt, 1 decrypt) and message; a request is
//    taken when valid and ready are both high
//  - rsp_bus returns result and error, held until the receiver takes it
// Throughput and sequencing:
//  - one request at a time; ready stays low from acceptance until the result
//    moves into the response register
//  - each exponent bit costs up to two modular multiplies on the shared unit,
//    each a registered multiply, then one reduction step per product bit,
//    then a hand-back of the remainder to the sequencer
//  - a rejected encrypt or zero modulus goes straight to done, zero exponent via step
// Reset: synchronous; registers return to modulus 143, exponents 7 and 103,
//  response register empty
// Stall: a finished result waits in the engine while the response register is
//  full and not being taken, and no new request is taken meanwhile

module rsa_modular_exponentiation
   import rsa_modexp_pkg::*;
#(
   parameter int MOD_BITS = MOD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [MOD_BITS-1:0]      csr_wdata,
   rsa_modexp_req_if.sink           req_bus,
   rsa_modexp_rsp_if.source         rsp_bus
);

   logic [MOD_BITS-1:0] modulus_ff;
   logic [MOD_BITS-1:0] pub_exp_ff;
   logic [MOD_BITS-1:0] priv_exp_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RES_BITS-1:0] rsp_result_ff;
   logic                rsp_error_ff;

   logic                req_take;
   logic                rsp_load;
   logic [MOD_BITS-1:0] eng_exp;
   logic [MOD_BITS-1:0] eng_result;
   logic                eng_error;
   unit_stat_type       eng_stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= MOD_BITS'(MODULUS_RST);
         pub_exp_ff  <= MOD_BITS'(PUB_EXP_RST);
         priv_exp_ff <= MOD_BITS'(PRIV_EXP_RST);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MODULUS:  modulus_ff  <= csr_wdata;
            CSR_PUB_EXP:  pub_exp_ff  <= csr_wdata;
            CSR_PRIV_EXP: priv_exp_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // request intake
   assign req_bus.ready = !eng_stat.busy;
   assign req_take      = req_bus.valid && !eng_stat.busy;
   assign eng_exp       = (req_bus.kind == KIND_DECRYPT) ? priv_exp_ff : pub_exp_ff;

   rsa_modexp_engine #(
      .MOD_BITS (MOD_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take),
      .kind     (req_bus.kind),
      .message  (MOD_BITS'(req_bus.message)),
      .exponent (eng_exp),
      .modulus  (modulus_ff),
      .ack      (rsp_load),
      .result   (eng_result),
      .error    (eng_error),
      .stat     (eng_stat)
   );

   // response register
   assign rsp_load = eng_stat.done && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_result_ff <= RES_BITS'(eng_result);
         rsp_error_ff  <= eng_error;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.result = rsp_result_ff;
   assign rsp_bus.error  = rsp_error_ff;

   // a taken request blocks intake in the next cycle
   a_busy_after_take : assert property (
      @(posedge clock) disable iff (reset)
      req_take |=> !req_bus.ready
   ) else $error("request intake not blocked after acceptance");

   // a finished result reaches an empty response register at once
   a_result_moves : assert property (
      @(posedge clock) disable iff (reset)
      eng_stat.done && !rsp_valid_ff |=> rsp_valid_ff
   ) else $error("finished result not moved to the response register");

   // a flagged response carries a zero result
   a_error_zero : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_ff |-> rsp_result_ff == '0
   ) else $error("error response with nonzero result");

endmodule
